[rtl/klt_pkg.sv]
// Package for the keyed lock table: request types and status codes.
// No dependencies.
package klt_pkg;
    typedef enum logic [1:0] {
        REQ_LOCK   = 2'd0,
        REQ_UNLOCK = 2'd1,
        REQ_CANCEL = 2'd2
    } t_req;

    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_QUEUED    = 3'd1;
    localparam logic [2:0] ST_BUSY      = 3'd2;
    localparam logic [2:0] ST_NOTFOUND  = 3'd3;
    localparam logic [2:0] ST_NOTHOLDER = 3'd4;
    localparam logic [2:0] ST_TABLEFULL = 3'd5;
    localparam logic [2:0] ST_QUEUEFULL = 3'd6;
endpackage

[rtl/klt_if.sv]
// Valid/ready channel interfaces for request and result items.
// Depends on no package.
interface klt_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] lock_key;
    logic [7:0]  requester_id;
    logic        may_wait;
    modport source (output valid, req_type, lock_key, requester_id, may_wait, input ready);
    modport sink   (input valid, req_type, lock_key, requester_id, may_wait, output ready);
endinterface

interface klt_rsp_if;
    logic       valid;
    logic       ready;
    logic [2:0] status;
    logic       grant_valid;
    logic [7:0] grant_id;
    logic       table_empty;
    modport source (output valid, status, grant_valid, grant_id, table_empty, input ready);
    modport sink   (input valid, status, grant_valid, grant_id, table_empty, output ready);
endinterface

[rtl/keyed_lock_table_fifo_waiters_top.sv]
// Keyed lock table with FIFO waiter queues, sequenced over a shared compare unit.
// Depends on klt_pkg and the channel interfaces in klt_if.sv.
//
// Usage: one request item enters on i_req (lock, unlock or cancel of a key by
// a requester); exactly one result item leaves on o_rsp with a status, an
// optional grant to the waiter that became holder, and a table-empty flag.
// One item is worked at a time; i_req.ready is high only while the sequencer
// is idle. The key search walks the table one entry per cycle through one
// shared key comparator, the waiter search walks the queue one slot at a
// time (a read state and a compare state per slot, for the registered read),
// and removal compacts the queue one slot at a time, a read state and a write
// state per slot, through the single queue memory port, then the table-empty
// flag is read from the valid bits. The sequencer is idle again, with
// i_req.ready high, in the cycle after the result is taken.
// The result is held in an output register until taken; a stalled receiver
// holds the sequencer in its result state and no new item is accepted.
// Reset clears the valid bits and counts; keys and queue slots need no clear.
module keyed_lock_table_fifo_waiters_top
    import klt_pkg::*;
#(
    parameter int NUM_KEYS    = 16,
    parameter int QUEUE_DEPTH = 8,
    parameter int KEY_BITS    = 32,
    parameter int ID_BITS     = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    klt_req_if.sink   i_req,
    klt_rsp_if.source o_rsp
);
    localparam int EW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int AW = EW + QW;

    typedef enum logic [3:0] {
        S_IDLE, S_KEY, S_DECIDE, S_IDRD, S_IDCMP, S_SHRD, S_SHWR, S_GRD, S_GCAP, S_RSP
    } t_state;

    t_state r_state;
    logic [NUM_KEYS-1:0] r_valid;
    logic [KEY_BITS-1:0] r_keys [NUM_KEYS];
    logic [CW-1:0]       r_cnt  [NUM_KEYS];
    logic [ID_BITS-1:0]  r_qmem [NUM_KEYS*QUEUE_DEPTH];
    logic [ID_BITS-1:0]  r_qrd;

    logic [1:0]          r_type;
    logic [KEY_BITS-1:0] r_key;
    logic [ID_BITS-1:0]  r_id;
    logic                r_wait;
    logic [EW-1:0]       r_ei;
    logic [EW:0]         r_scan;
    logic                r_found, r_free_ok;
    logic [EW-1:0]       r_hit, r_free;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_n;
    logic                r_head_rm;

    logic                r_ov;
    logic [2:0]          r_st;
    logic                r_gv;
    logic [7:0]          r_gid;
    logic                r_emp;

    // Queue memory port, driven by the sequencer.
    logic          q_we;
    logic [AW-1:0] q_wa, q_ra;
    logic [ID_BITS-1:0] q_wd;

    function automatic logic [AW-1:0] qaddr(logic [EW-1:0] e, logic [CW-1:0] p);
        return AW'(e) * AW'(QUEUE_DEPTH) + AW'(p);
    endfunction

    // Shared key comparator.
    logic key_eq;
    assign key_eq = r_valid[r_ei] && (r_keys[r_ei] == r_key);

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_ov;
    assign o_rsp.status      = r_st;
    assign o_rsp.grant_valid = r_gv;
    assign o_rsp.grant_id    = r_gid;
    assign o_rsp.table_empty = r_emp;

    always_comb begin
        q_we = 1'b0;
        q_wa = qaddr(r_hit, r_pos);
        q_wd = r_id;
        q_ra = qaddr(r_hit, r_pos);
        case (r_state)
            S_DECIDE: begin
                if (!r_found) q_wa = qaddr(r_free, '0);
                else q_wa = qaddr(r_hit, r_cnt[r_hit]);
                q_we = (r_type == REQ_LOCK) &&
                       ((!r_found && r_free_ok) ||
                        (r_found && r_wait && r_cnt[r_hit] < CW'(QUEUE_DEPTH)));
            end
            S_SHRD: q_ra = qaddr(r_hit, r_pos + CW'(1));
            S_SHWR: begin
                q_we = 1'b1;
                q_wd = r_qrd;
            end
            S_GRD: q_ra = qaddr(r_hit, '0);
            default: ;
        endcase
    end

    // Queue memory with registered read.
    always_ff @(posedge i_clk) begin
        if (q_we) r_qmem[q_wa] <= q_wd;
        r_qrd <= r_qmem[q_ra];
    end

    // Sequencer, table state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= '0;
            r_ov    <= 1'b0;
            for (int k = 0; k < NUM_KEYS; k++) r_cnt[k] <= '0;
        end else begin
            case (r_state)
                S_IDLE: if (i_req.valid) begin
                    r_type    <= i_req.req_type;
                    r_key     <= KEY_BITS'(i_req.lock_key);
                    r_id      <= i_req.requester_id[ID_BITS-1:0];
                    r_wait    <= i_req.may_wait;
                    r_ei      <= '0;
                    r_scan    <= '0;
                    r_found   <= 1'b0;
                    r_free_ok <= 1'b0;
                    r_gv      <= 1'b0;
                    r_gid     <= '0;
                    r_state   <= S_KEY;
                end
                S_KEY: begin
                    if (key_eq && !r_found) begin
                        r_found <= 1'b1;
                        r_hit   <= r_ei;
                    end
                    if (!r_valid[r_ei] && !r_free_ok) begin
                        r_free_ok <= 1'b1;
                        r_free    <= r_ei;
                    end
                    r_ei   <= r_ei + EW'(1);
                    r_scan <= r_scan + (EW+1)'(1);
                    if (r_scan == (EW+1)'(NUM_KEYS - 1)) r_state <= S_DECIDE;
                end
                S_DECIDE: begin
                    r_pos   <= '0;
                    r_n     <= r_cnt[r_hit];
                    case (r_type)
                        REQ_LOCK: begin
                            r_state <= S_RSP;
                            if (!r_found) begin
                                if (r_free_ok) begin
                                    r_valid[r_free] <= 1'b1;
                                    r_keys[r_free]  <= r_key;
                                    r_cnt[r_free]   <= CW'(1);
                                    r_st <= ST_DONE;
                                end else r_st <= ST_TABLEFULL;
                            end else if (!r_wait) r_st <= ST_BUSY;
                            else if (r_cnt[r_hit] >= CW'(QUEUE_DEPTH)) r_st <= ST_QUEUEFULL;
                            else begin
                                r_cnt[r_hit] <= r_cnt[r_hit] + CW'(1);
                                r_st <= ST_QUEUED;
                            end
                        end
                        REQ_UNLOCK, REQ_CANCEL: begin
                            if (!r_found) begin
                                r_st    <= ST_NOTFOUND;
                                r_state <= S_RSP;
                            end else r_state <= S_IDRD;
                        end
                        default: begin
                            r_st    <= ST_NOTFOUND;
                            r_state <= S_RSP;
                        end
                    endcase
                end
                S_IDRD: r_state <= S_IDCMP;
                S_IDCMP: begin
                    if (r_qrd == r_id) begin
                        if (r_type == REQ_UNLOCK && r_pos != '0) begin
                            r_st <= ST_NOTHOLDER;
                            r_state <= S_RSP;
                        end else begin
                            r_st <= ST_DONE;
                            r_state <= S_SHRD;
                        end
                    end else if (r_type == REQ_UNLOCK && r_pos == '0) begin
                        r_st <= ST_NOTHOLDER;
                        r_state <= S_RSP;
                    end else if (r_pos + CW'(1) >= r_n) begin
                        r_st <= (r_type == REQ_UNLOCK) ? ST_NOTHOLDER : ST_NOTFOUND;
                        r_state <= S_RSP;
                    end else begin
                        r_pos <= r_pos + CW'(1);
                        r_state <= S_IDRD;
                    end
                end
                S_SHRD: begin
                    if (r_pos + CW'(1) >= r_n) begin
                        r_cnt[r_hit] <= r_n - CW'(1);
                        if (r_n == CW'(1)) begin
                            r_valid[r_hit] <= 1'b0;
                            r_state <= S_RSP;
                        end else if (r_head_rm) r_state <= S_GRD;
                        else r_state <= S_RSP;
                    end else r_state <= S_SHWR;
                end
                S_SHWR: begin
                    r_pos <= r_pos + CW'(1);
                    r_state <= S_SHRD;
                end
                S_GRD: r_state <= S_GCAP;
                S_GCAP: begin
                    r_gv  <= 1'b1;
                    r_gid <= 8'(r_qrd);
                    r_state <= S_RSP;
                end
                S_RSP: begin
                    if (!r_ov) begin
                        r_ov  <= 1'b1;
                        r_emp <= (r_valid == '0);
                    end else if (o_rsp.ready) begin
                        r_ov    <= 1'b0;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // The removed slot was the head when compaction started at slot zero.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDCMP) r_head_rm <= (r_pos == '0);
    end
endmodule

[rtl/klt_checker.sv]
// Port-level checks for the keyed lock table top level, with its bind.
// Depends on klt_pkg for status codes.
module klt_checker
    import klt_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       req_valid,
    input logic       req_ready,
    input logic       rsp_valid,
    input logic       rsp_ready,
    input logic [2:0] status,
    input logic       grant_valid,
    input logic [7:0] grant_id
);
    // No new item is taken while a result waits.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !req_ready) else $error("request taken while result pending");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
        else $error("result dropped under stall");
    // Grants come only with a completed operation.
    a_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && grant_valid |-> status == ST_DONE) else $error("grant on failure");
    // Status codes stay in range.
    a_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> status != 3'd7) else $error("bad status");
    // No grant id without a grant.
    a_gid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !grant_valid |-> grant_id == 8'd0) else $error("stray grant id");
endmodule

bind keyed_lock_table_fifo_waiters_top klt_checker u_klt_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .req_valid(i_req.valid), .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid), .rsp_ready(o_rsp.ready),
    .status(o_rsp.status), .grant_valid(o_rsp.grant_valid), .grant_id(o_rsp.grant_id)
);
